>>> src/tccw_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the text console character writer.
// No dependencies; every other file of the block imports this package.
package tccw_pkg;

   // Screen geometry
   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = ROWS * COLS;

   // Field widths
   localparam int COL_W     = 7;
   localparam int ROW_W     = 5;
   localparam int OFS_W     = 11;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int COLOR_W   = 4;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CELL_W    = CHAR_W + ATTR_W;

   // Cell store addressing
   localparam int CELL_AW   = $clog2(CELLS);
   localparam int CELL_XW   = ROW_W + $clog2(COLS + 1) + COL_W + 1;
   localparam int COPY_LAST = (ROWS - 1) * COLS - 1;

   // Opcodes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
   localparam int                TAB_STOP   = 8;

   // Attribute after reset
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
   localparam logic [COLOR_W-1:0] RESET_FG  = 4'hF;
   localparam logic [COLOR_W-1:0] RESET_BG  = 4'h0;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 2'd1;

   // Sweep modes of the store sequencer
   localparam int SWP_W = 2;
   localparam logic [SWP_W-1:0] SWP_NONE = 2'd0;
   localparam logic [SWP_W-1:0] SWP_INIT = 2'd1;
   localparam logic [SWP_W-1:0] SWP_FILL = 2'd2;
   localparam logic [SWP_W-1:0] SWP_COPY = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  cell_row;
      logic [COL_W-1:0]  cell_col;
   } req_payload_type;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic [OFS_W-1:0]  cursor_offset;
      logic [CHAR_W-1:0] read_char;
      logic [ATTR_W-1:0] read_attr;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic             exec;
      logic [SWP_W-1:0] sweep_mode;
      logic             load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic put_scroll;
      logic is_clear;
      logic sweep_last;
   } status_type;

   function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
      logic [CELL_XW-1:0] full;
      full = CELL_XW'(r) * CELL_XW'(COLS) + CELL_XW'(c);
      return full[CELL_AW-1:0];
   endfunction

endpackage

>>> src/tccw_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the text console character writer: request, response, csr.
// Depends on tccw_pkg for field widths.
interface tccw_req_if import tccw_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [CHAR_W-1:0] char_code;
   logic [ROW_W-1:0]  cell_row;
   logic [COL_W-1:0]  cell_col;

   modport source (output valid, output opcode, output char_code,
                   output cell_row, output cell_col, input ready);
   modport sink   (input valid, input opcode, input char_code,
                   input cell_row, input cell_col, output ready);
endinterface

interface tccw_rsp_if import tccw_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  cursor_col;
   logic [ROW_W-1:0]  cursor_row;
   logic [OFS_W-1:0]  cursor_offset;
   logic [CHAR_W-1:0] read_char;
   logic [ATTR_W-1:0] read_attr;

   modport source (output valid, output cursor_col, output cursor_row,
                   output cursor_offset, output read_char, output read_attr,
                   input ready);
   modport sink   (input valid, input cursor_col, input cursor_row,
                   input cursor_offset, input read_char, input read_attr,
                   output ready);
endinterface

interface tccw_csr_if import tccw_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COLOR_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/text_console_char_writer.sv
`timescale 1ns / 1ps
// Top level of the text console character writer: joins controller and datapath.
// Depends on tccw_pkg, tccw_ifs, tccw_ctrl and tccw_dp.
//
// req_ch: one command per beat: put character, clear screen or read cell.
// rsp_ch: exactly one beat per request, in order: cursor, its linear offset and,
//   for an in-range read, the stored character and attribute (zero otherwise).
// csr_ch: writes fg_color (index 0) and bg_color (index 1); always ready, to be
//   used only while no request is in flight.
// Sequence: a request is taken in S_IDLE; put without scroll, read and unused
//   opcodes go to S_DONE. A put that scrolls copies (ROWS-1)*COLS cells up,
//   drains the last copy write, then fills the COLS cells of the bottom row.
//   Clear fills all ROWS*COLS cells; the next request is taken after S_DONE.
//   Sweeps use the store's separate read and write ports, one cell a cycle.
// Reset: synchronous, active high. Cursor home, colors white on black, then a
//   pass over all ROWS*COLS cells blanks the store with req_ch.ready low.
// Stall: the response waits in an output register; the next finished response
//   waits in the controller and no further request is taken until it moves.
module text_console_char_writer import tccw_pkg::*; (
   input logic        clock,
   input logic        reset,
   tccw_req_if.sink   req_ch,
   tccw_rsp_if.source rsp_ch,
   tccw_csr_if.sink   csr_ch
);

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;

   // csr writes are always accepted
   assign csr_ch.ready = 1'b1;

   assign req_payload.opcode    = req_ch.opcode;
   assign req_payload.char_code = req_ch.char_code;
   assign req_payload.cell_row  = req_ch.cell_row;
   assign req_payload.cell_col  = req_ch.cell_col;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccw_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_payload),
      .csr_we    (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp_payload)
   );

   assign rsp_ch.cursor_col    = rsp_payload.cursor_col;
   assign rsp_ch.cursor_row    = rsp_payload.cursor_row;
   assign rsp_ch.cursor_offset = rsp_payload.cursor_offset;
   assign rsp_ch.read_char     = rsp_payload.read_char;
   assign rsp_ch.read_attr     = rsp_payload.read_attr;

endmodule

>>> src/tccw_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM of the text console character writer: sequencing of
// items, store sweeps and the response valid. Depends on tccw_pkg.
module tccw_ctrl import tccw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_COPY  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_FILL  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in       = state_ff;
      cmd.exec       = 1'b0;
      cmd.sweep_mode = SWP_NONE;
      cmd.load_rsp   = 1'b0;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep_mode = SWP_INIT;
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               if (status.is_clear)        state_in = S_FILL;
               else if (status.put_scroll) state_in = S_COPY;
               else                        state_in = S_DONE;
            end
         end
         S_COPY: begin
            cmd.sweep_mode = SWP_COPY;
            if (status.sweep_last) state_in = S_DRAIN;
         end
         // last copied cell lands in the store here
         S_DRAIN: begin
            state_in = S_FILL;
         end
         S_FILL: begin
            cmd.sweep_mode = SWP_FILL;
            if (status.sweep_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp)     rsp_valid_in = 1'b1;
      else if (rsp_ready)   rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/tccw_dp.sv
`timescale 1ns / 1ps
// Datapath of the text console character writer: cell store, cursor,
// color registers, sweep counter and response register. Depends on tccw_pkg.
module tccw_dp import tccw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  req_payload_type      req,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_data,
   input  cmd_type              cmd,
   output status_type           status,
   output rsp_payload_type      rsp
);

   logic [CELL_W-1:0] cell_mem [CELLS];
   logic [CELL_W-1:0] rdata_ff;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COLOR_W-1:0] fg_ff, fg_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;
   logic [CELL_AW-1:0] idx_ff, idx_in;
   logic               cp_wr_ff, cp_wr_in;
   logic [CELL_AW-1:0] cp_waddr_ff;
   logic               rd_hit_ff, rd_hit_in;
   rsp_payload_type    rsp_ff;

   logic [ATTR_W-1:0]  attr;
   logic [COL_W:0]     col_inc, tab_col;
   logic [ROW_W:0]     row_inc;
   logic [COL_W-1:0]   col_nx;
   logic [ROW_W-1:0]   row_nx;
   logic               adv, wr_char, scroll;
   logic               is_put, is_clear, is_read, rd_in_range;

   logic               mem_we, mem_re;
   logic [CELL_AW-1:0] mem_waddr, mem_raddr;
   logic [CELL_W-1:0]  mem_wdata;

   assign attr     = {bg_ff, fg_ff};
   assign is_put   = (req.opcode == OP_PUT);
   assign is_clear = (req.opcode == OP_CLEAR);
   assign is_read  = (req.opcode == OP_READ);
   assign rd_in_range = ({1'b0, req.cell_row} < (ROW_W+1)'(ROWS)) &&
                        ({1'b0, req.cell_col} < (COL_W+1)'(COLS));

   // put-character cursor movement
   assign col_inc = {1'b0, col_ff} + (COL_W+1)'(1);
   assign tab_col = ({1'b0, col_ff} + (COL_W+1)'(TAB_STOP)) & ~(COL_W+1)'(TAB_STOP - 1);
   assign row_inc = {1'b0, row_ff} + (ROW_W+1)'(1);

   always_comb begin
      col_nx  = col_ff;
      adv     = 1'b0;
      wr_char = 1'b0;
      priority if (req.char_code == CH_BS) begin
         if (col_ff != '0) col_nx = col_ff - COL_W'(1);
      end else if (req.char_code == CH_TAB) begin
         if (tab_col >= (COL_W+1)'(COLS)) begin
            col_nx = '0;
            adv    = 1'b1;
         end else begin
            col_nx = tab_col[COL_W-1:0];
         end
      end else if (req.char_code == CH_CR) begin
         col_nx = '0;
      end else if (req.char_code == CH_LF) begin
         col_nx = '0;
         adv    = 1'b1;
      end else begin
         wr_char = 1'b1;
         if (col_inc >= (COL_W+1)'(COLS)) begin
            col_nx = '0;
            adv    = 1'b1;
         end else begin
            col_nx = col_inc[COL_W-1:0];
         end
      end
   end

   assign scroll = adv && (row_inc >= (ROW_W+1)'(ROWS));
   assign row_nx = !adv ? row_ff : (scroll ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0]);

   // status
   assign status.put_scroll = is_put && scroll;
   assign status.is_clear   = is_clear;
   assign status.sweep_last = (cmd.sweep_mode == SWP_COPY) ?
                              (idx_ff == CELL_AW'(COPY_LAST)) :
                              (idx_ff == CELL_AW'(CELLS - 1));

   // store ports; a pending copy write has the write port first
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = {attr, BLANK_CHAR};
      if (cp_wr_ff) begin
         mem_we    = 1'b1;
         mem_waddr = cp_waddr_ff;
         mem_wdata = rdata_ff;
      end else if (cmd.sweep_mode == SWP_INIT) begin
         mem_we    = 1'b1;
         mem_wdata = {RESET_ATTR, BLANK_CHAR};
      end else if (cmd.sweep_mode == SWP_FILL) begin
         mem_we    = 1'b1;
      end else if (cmd.exec && is_put && wr_char) begin
         mem_we    = 1'b1;
         mem_waddr = cell_addr(row_ff, col_ff);
         mem_wdata = {attr, req.char_code};
      end
   end

   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = cell_addr(req.cell_row, req.cell_col);
      if (cmd.sweep_mode == SWP_COPY) begin
         mem_re    = 1'b1;
         mem_raddr = idx_ff + CELL_AW'(COLS);
      end else if (cmd.exec && is_read && rd_in_range) begin
         mem_re    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= cell_mem[mem_raddr];
   end

   // control registers
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      idx_in    = idx_ff;
      rd_hit_in = rd_hit_ff;
      cp_wr_in  = (cmd.sweep_mode == SWP_COPY);
      if (cmd.exec) begin
         idx_in    = '0;
         rd_hit_in = is_read && rd_in_range;
         if (is_put) begin
            col_in = col_nx;
            row_in = row_nx;
         end else if (is_clear) begin
            col_in = '0;
            row_in = '0;
         end
      end else if (cmd.sweep_mode != SWP_NONE) begin
         idx_in = idx_ff + CELL_AW'(1);
      end
   end

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_we && csr_index == CSR_FG_COLOR) fg_in = csr_data;
      if (csr_we && csr_index == CSR_BG_COLOR) bg_in = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         idx_ff    <= '0;
         cp_wr_ff  <= 1'b0;
         rd_hit_ff <= 1'b0;
         fg_ff     <= RESET_FG;
         bg_ff     <= RESET_BG;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         idx_ff    <= idx_in;
         cp_wr_ff  <= cp_wr_in;
         rd_hit_ff <= rd_hit_in;
         fg_ff     <= fg_in;
         bg_ff     <= bg_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_waddr_ff <= idx_ff;
      if (cmd.load_rsp) begin
         rsp_ff.cursor_col    <= col_ff;
         rsp_ff.cursor_row    <= row_ff;
         rsp_ff.cursor_offset <= OFS_W'(cell_addr(row_ff, col_ff));
         rsp_ff.read_char     <= rd_hit_ff ? rdata_ff[CHAR_W-1:0] : '0;
         rsp_ff.read_attr     <= rd_hit_ff ? rdata_ff[CELL_W-1:CHAR_W] : '0;
      end
   end

   assign rsp = rsp_ff;

endmodule
